[design/sal_pkg.sv]
// Package for the sentinel-terminated array list: request codes, controller
// states, the shift control word and the scan word that travel along the cells.
// No dependencies.
package sal_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned REQ_W  = 4;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned LEN_W  = 7;

  // Every slot and the marker come out of reset as all ones.
  localparam logic [DATA_W-1:0] SLOT_RESET = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_GET       = 4'd0,
    REQ_SET       = 4'd1,
    REQ_INS_FIRST = 4'd2,
    REQ_INS_AT    = 4'd3,
    REQ_INS_LAST  = 4'd4,
    REQ_DEL_FIRST = 4'd5,
    REQ_DEL_AT    = 4'd6,
    REQ_DEL_LAST  = 4'd7,
    REQ_SEARCH    = 4'd8
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OP,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SH_WRITE,
    SH_UP,
    SH_DOWN
  } shift_kind_t;

  typedef struct packed {
    logic        en;
    shift_kind_t kind;
  } shift_ctrl_t;

  typedef struct packed {
    logic valid;
    logic alive;
    logic hit;
  } tok_t;

endpackage

[design/sal_cell.sv]
// One slot of the array list and its stage of the scan chain.
// Depends on sal_pkg.
module sal_cell import sal_pkg::*; #(
  parameter int LW = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [LW-1:0]     pos,
  input  logic [LW-1:0]     lo,
  input  logic [LW-1:0]     hi,
  input  shift_ctrl_t       ctrl,
  input  logic [DATA_W-1:0] marker,
  input  logic [DATA_W-1:0] wr_value,
  input  logic [DATA_W-1:0] slot_below,
  input  logic [DATA_W-1:0] slot_above,
  output logic [DATA_W-1:0] slot,
  input  tok_t              tok_in,
  input  logic [DATA_W-1:0] rd_in,
  input  logic [LW-1:0]     cnt_in,
  output tok_t              tok_out,
  output logic [DATA_W-1:0] rd_out,
  output logic [LW-1:0]     cnt_out
);

  logic alive_c;
  logic hit_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= SLOT_RESET;
    end else if (ctrl.en) begin
      case (ctrl.kind)
        SH_WRITE: begin
          if (pos == lo) slot <= wr_value;
        end
        SH_UP: begin
          if (pos == lo) slot <= wr_value;
          else if (pos > lo && pos <= hi) slot <= slot_below;
        end
        SH_DOWN: begin
          if (pos >= lo && pos < hi) slot <= slot_above;
          else if (pos == hi) slot <= marker;
        end
        default: begin
          slot <= slot;
        end
      endcase
    end
  end

  // The list is still running here only if no marker has been seen so far.
  assign alive_c = tok_in.alive && (slot != marker);
  assign hit_c   = tok_in.hit || (alive_c && (slot == wr_value));

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.valid <= tok_in.valid;
      tok_out.alive <= alive_c;
      tok_out.hit   <= hit_c;
    end
  end

  always_ff @(posedge clk) begin
    rd_out  <= (pos == lo) ? slot : rd_in;
    cnt_out <= cnt_in + LW'(alive_c);
  end

endmodule

[design/sentinel_array_list.sv]
// Top level of the sentinel-terminated array list: controller, request decode
// and the row of sal_cell slots. Depends on sal_pkg and sal_cell.
//
// Usage
//   Requests arrive on req_valid/req_ready with req_type, index and value;
//   each accepted word gives exactly one response word on rsp_valid/rsp_ready
//   carrying read_value, found, list_length and applied.
//   The marker value is written on cfg_valid/cfg_ready/cfg_data; cfg_ready is
//   always high. A marker write starts a rescan of the row to find the new
//   list length, and requests are held off until that rescan has finished.
// Operation
//   One request is in flight at a time. It applies its shift or write in all
//   cells at once in the apply state, then a scan word walks the chain of
//   DEPTH cells, one cell per cycle, to count the length and gather the read
//   and search results. A new request is taken only once the scan of the last
//   one has finished and the block is back in its idle state.
// Reset
//   rst is synchronous and active high. Every slot and the marker become all
//   ones, so the list is empty; no rescan is needed after reset.
// Back-pressure
//   The response sits in an output register until rsp_ready is seen. While
//   it waits a new request may still be taken and worked on; it stops only
//   at its finished state until the output register is free.
module sentinel_array_list import sal_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  logic [REQ_W-1:0]         req_type,
  input  logic [IDX_W-1:0]         index,
  input  logic signed [DATA_W-1:0] value,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output logic signed [DATA_W-1:0] read_value,
  output logic                     found,
  output logic [LEN_W-1:0]         list_length,
  output logic                     applied,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic signed [DATA_W-1:0] cfg_data
);

  // LW holds a length from 0 to DEPTH; PW also holds any request index.
  localparam int LW = $clog2(DEPTH + 1);
  localparam int PW = (LW > IDX_W) ? LW : IDX_W;

  state_t state, state_next;

  logic [REQ_W-1:0]  req_op_q;
  logic [IDX_W-1:0]  req_idx_q;
  logic [DATA_W-1:0] req_val_q;
  logic [DATA_W-1:0] marker_q;
  logic [LW-1:0]     len_q;
  logic              rescan_q;
  logic              report_q;
  logic              applied_q;
  logic              seed_q;
  logic [DATA_W-1:0] rd_res_q;
  logic              hit_res_q;

  logic              rsp_valid_q;
  logic [DATA_W-1:0] read_value_q;
  logic              found_q;
  logic [LEN_W-1:0]  list_length_q;
  logic              applied_out_q;

  logic              req_fire;
  logic              cfg_fire;
  logic              start_rescan;
  logic              cell_en;
  logic              out_free;

  // Request decode, taken from the held request and the current length.
  logic [PW-1:0]     idx_p;
  logic [LW-1:0]     idx_l;
  logic [LW-1:0]     len_m1;
  logic              idx_ok;
  logic              idx_lt_len;
  logic              not_full;
  logic              not_empty;
  shift_ctrl_t       dec_ctrl;
  shift_ctrl_t       cell_ctrl;
  logic [LW-1:0]     dec_lo;
  logic [LW-1:0]     dec_hi;
  logic              dec_applied;

  // Cell row.
  logic [DATA_W-1:0] slot_w [DEPTH];
  tok_t              tok_w  [DEPTH];
  logic [DATA_W-1:0] rd_w   [DEPTH];
  logic [LW-1:0]     cnt_w  [DEPTH];
  tok_t              seed_tok;
  logic              scan_end;

  assign req_fire  = req_valid && req_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !rsp_valid_q || rsp_ready;
  assign scan_end  = (state == ST_SCAN) && tok_w[DEPTH-1].valid;

  assign idx_p      = PW'(req_idx_q);
  assign idx_l      = LW'(idx_p);
  assign len_m1     = len_q - LW'(1);
  assign idx_ok     = idx_p < PW'(DEPTH);
  assign idx_lt_len = idx_p < PW'(len_q);
  assign not_full   = len_q < LW'(DEPTH);
  assign not_empty  = len_q != '0;

  always_comb begin
    dec_ctrl.en   = 1'b0;
    dec_ctrl.kind = SH_WRITE;
    dec_lo        = idx_l;
    dec_hi        = len_q;
    dec_applied   = 1'b0;
    case (req_op_q)
      REQ_GET: begin
        dec_applied = idx_ok;
      end
      REQ_SET: begin
        dec_ctrl.en = idx_ok;
        dec_applied = idx_ok;
      end
      REQ_INS_FIRST: begin
        dec_ctrl.en   = not_full;
        dec_ctrl.kind = SH_UP;
        dec_lo        = '0;
        dec_applied   = not_full;
      end
      REQ_INS_AT: begin
        dec_ctrl.en   = not_full && idx_lt_len;
        dec_ctrl.kind = SH_UP;
        dec_applied   = not_full && idx_lt_len;
      end
      REQ_INS_LAST: begin
        dec_ctrl.en   = not_full;
        dec_ctrl.kind = SH_UP;
        dec_lo        = len_q;
        dec_applied   = not_full;
      end
      REQ_DEL_FIRST: begin
        dec_ctrl.en   = not_empty;
        dec_ctrl.kind = SH_DOWN;
        dec_lo        = '0;
        dec_hi        = len_m1;
        dec_applied   = not_empty;
      end
      REQ_DEL_AT: begin
        dec_ctrl.en   = not_empty && idx_lt_len;
        dec_ctrl.kind = SH_DOWN;
        dec_hi        = len_m1;
        dec_applied   = not_empty && idx_lt_len;
      end
      REQ_DEL_LAST: begin
        dec_ctrl.en   = not_empty;
        dec_ctrl.kind = SH_DOWN;
        dec_lo        = len_m1;
        dec_hi        = len_m1;
        dec_applied   = not_empty;
      end
      REQ_SEARCH: begin
        dec_applied = 1'b1;
      end
      default: begin
        dec_applied = 1'b0;
      end
    endcase
  end

  // The store changes only in the apply state.
  assign cell_ctrl.en   = dec_ctrl.en && cell_en;
  assign cell_ctrl.kind = dec_ctrl.kind;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (rescan_q) state_next = ST_SCAN;
        else if (req_valid) state_next = ST_OP;
      end
      ST_OP: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end) state_next = report_q ? ST_DONE : ST_IDLE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Controller outputs.
  always_comb begin
    req_ready    = 1'b0;
    cell_en      = 1'b0;
    start_rescan = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready    = !rescan_q;
        start_rescan = rescan_q;
      end
      ST_OP: begin
        cell_en = 1'b1;
      end
      ST_SCAN: begin
        cell_en = 1'b0;
      end
      ST_DONE: begin
        cell_en = 1'b0;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      marker_q    <= SLOT_RESET;
      len_q       <= '0;
      rescan_q    <= 1'b0;
      report_q    <= 1'b0;
      seed_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state  <= state_next;
      seed_q <= (state_next == ST_SCAN) && (state != ST_SCAN);
      if (cfg_fire) begin
        marker_q <= cfg_data;
        rescan_q <= 1'b1;
      end else if (start_rescan) begin
        rescan_q <= 1'b0;
      end
      if (req_fire) report_q <= 1'b1;
      else if (start_rescan) report_q <= 1'b0;
      if (scan_end) len_q <= cnt_w[DEPTH-1];
      if (state == ST_DONE && out_free) rsp_valid_q <= 1'b1;
      else if (rsp_ready) rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_op_q  <= req_type;
      req_idx_q <= index;
      req_val_q <= value;
    end
    if (cell_en) applied_q <= dec_applied;
    if (scan_end) begin
      rd_res_q  <= rd_w[DEPTH-1];
      hit_res_q <= tok_w[DEPTH-1].hit;
    end
    if (state == ST_DONE && out_free) begin
      read_value_q  <= (req_op_q == REQ_GET && idx_ok) ? rd_res_q : '0;
      found_q       <= (req_op_q == REQ_SEARCH) && hit_res_q;
      list_length_q <= LEN_W'(len_q);
      applied_out_q <= applied_q;
    end
  end

  // The scan word enters cell 0 in the first scan cycle, after any shift.
  assign seed_tok.valid = seed_q;
  assign seed_tok.alive = 1'b1;
  assign seed_tok.hit   = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] below_w;
    logic [DATA_W-1:0] above_w;
    tok_t              tin_w;
    logic [DATA_W-1:0] rin_w;
    logic [LW-1:0]     cin_w;

    if (i == 0) begin : g_first
      assign below_w = marker_q;
      assign tin_w   = seed_tok;
      assign rin_w   = '0;
      assign cin_w   = '0;
    end else begin : g_rest
      assign below_w = slot_w[i-1];
      assign tin_w   = tok_w[i-1];
      assign rin_w   = rd_w[i-1];
      assign cin_w   = cnt_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign above_w = marker_q;
    end else begin : g_inner
      assign above_w = slot_w[i+1];
    end

    sal_cell #(
      .LW (LW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .pos        (LW'(i)),
      .lo         (dec_lo),
      .hi         (dec_hi),
      .ctrl       (cell_ctrl),
      .marker     (marker_q),
      .wr_value   (req_val_q),
      .slot_below (below_w),
      .slot_above (above_w),
      .slot       (slot_w[i]),
      .tok_in     (tin_w),
      .rd_in      (rin_w),
      .cnt_in     (cin_w),
      .tok_out    (tok_w[i]),
      .rd_out     (rd_w[i]),
      .cnt_out    (cnt_w[i])
    );
  end

  assign rsp_valid   = rsp_valid_q;
  assign read_value  = read_value_q;
  assign found       = found_q;
  assign list_length = list_length_q;
  assign applied     = applied_out_q;

endmodule

[design/sentinel_array_list_checker.sv]
// Port-level checks for sentinel_array_list and the bind that attaches them.
// Depends on sal_pkg and on the port names of sentinel_array_list.
module sentinel_array_list_checker import sal_pkg::*; #(
  parameter int DEPTH = 64
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     req_valid,
  input logic                     req_ready,
  input logic                     rsp_valid,
  input logic                     rsp_ready,
  input logic signed [DATA_W-1:0] read_value,
  input logic                     found,
  input logic [LEN_W-1:0]         list_length,
  input logic                     applied
);

  // A stalled response word holds its read value and its length.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_value) && $stable(list_length))
    else $error("response word changed while stalled");

  // Only one request is worked on at a time.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  // A search hit is always reported as done.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && found |-> applied)
    else $error("found without applied");

  // The length never exceeds the number of slots.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (list_length <= DEPTH))
    else $error("list length beyond capacity");

  // A response never follows straight on from the acceptance of a request.
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_valid && req_ready))
    else $error("response appeared one cycle after a request");

endmodule

bind sentinel_array_list sentinel_array_list_checker #(.DEPTH(DEPTH)) u_checker (.*);

[sim/sentinel_array_list_tb.sv]
// Self-checking testbench for sentinel_array_list: random and directed request words
// are checked against a predictor of the slot store, under several empty-marker settings.
// Depends on sal_pkg and the sentinel_array_list RTL.
`timescale 1ns / 1ps

module sentinel_array_list_tb;
  import sal_pkg::*;

  localparam int LIST_DEPTH = 64;
  // Request codes with no operation behind them.
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 4'd9;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 4'd15;
  // Mismatch reports beyond this count are counted but not printed.
  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [IDX_W-1:0]  slot;
    logic [DATA_W-1:0] data;
  } req_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] rd_val;
    logic              hit;
    logic [LEN_W-1:0]  len;
    logic              ok;
  } rsp_word_t;

  logic              clk;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  logic [REQ_W-1:0]  req_type  = '0;
  logic [IDX_W-1:0]  index     = '0;
  logic [DATA_W-1:0] value     = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  logic [DATA_W-1:0] read_value;
  logic              found;
  logic [LEN_W-1:0]  list_length;
  logic              applied;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [DATA_W-1:0] cfg_data  = '0;

  // Predictor state: our own image of the slot store and of the marker.
  logic [DATA_W-1:0] slot_image [LIST_DEPTH];
  logic [DATA_W-1:0] marker_img;

  req_word_t         pending_reqs[$];
  logic [DATA_W-1:0] pending_markers[$];
  rsp_word_t         awaited_rsps[$];

  // The marker the stimulus is currently built around, and whether idling is on.
  logic [DATA_W-1:0] marker_now = SLOT_RESET;
  bit                gaps_on    = 1'b1;

  int send_gap;
  int stall_left;
  int mismatches   = 0;
  int reqs_taken   = 0;
  int rsps_seen    = 0;
  int full_seen    = 0;
  int refused_seen = 0;
  int markers_set  = 0;

  sentinel_array_list #(.DEPTH(LIST_DEPTH)) DUT (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_type   (req_type),
    .index      (index),
    .value      (value),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .read_value (read_value),
    .found      (found),
    .list_length(list_length),
    .applied    (applied),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Length of the list as it stands: the position of the first marker slot.
  function automatic int count_len();
    int n;
    n = 0;
    while (n < LIST_DEPTH && slot_image[n] != marker_img) n++;
    return n;
  endfunction

  // Applies one request word to the slot image and returns the response word it
  // should produce. Inserts shift the tail up; deletes shift it down and put the
  // marker into the slot that was last in the list.
  function automatic rsp_word_t list_step(logic [REQ_W-1:0] op, logic [IDX_W-1:0] at,
                                          logic [DATA_W-1:0] val);
    rsp_word_t res;
    int        len;
    int        from;
    int        k;
    res = '0;
    len = count_len();
    case (op)
      REQ_GET: begin
        // Reads anywhere, also past the end of the list.
        res.rd_val = slot_image[at];
        res.ok     = 1'b1;
      end
      REQ_SET: begin
        // No length check, so a set can lengthen or cut the list.
        slot_image[at] = val;
        res.ok         = 1'b1;
      end
      REQ_INS_FIRST, REQ_INS_AT, REQ_INS_LAST: begin
        from = (op == REQ_INS_FIRST) ? 0 : (op == REQ_INS_AT) ? int'(at) : len;
        // A full list refuses every insert; insert-at needs an index inside the list.
        if (len < LIST_DEPTH && (op != REQ_INS_AT || from < len)) begin
          for (k = len; k > from; k--) slot_image[k] = slot_image[k-1];
          slot_image[from] = val;
          res.ok           = 1'b1;
        end
      end
      REQ_DEL_FIRST, REQ_DEL_AT, REQ_DEL_LAST: begin
        from = (op == REQ_DEL_FIRST) ? 0 : (op == REQ_DEL_AT) ? int'(at) : len - 1;
        if (len > 0 && from < len) begin
          for (k = from; k + 1 < len; k++) slot_image[k] = slot_image[k+1];
          slot_image[len-1] = marker_img;
          res.ok            = 1'b1;
        end
      end
      REQ_SEARCH: begin
        for (k = 0; k < len; k++) if (slot_image[k] == val) res.hit = 1'b1;
        res.ok = 1'b1;
      end
      default: ;
    endcase
    res.len = LEN_W'(count_len());
    return res;
  endfunction

  // Element values: often a small pool so that searches hit, now and then the
  // extremes or the marker itself, otherwise anything.
  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return marker_now;
    if (r < 44) return DATA_W'($urandom_range(0, 7));
    if (r < 47) return 32'h7FFF_FFFF;
    if (r < 50) return 32'h8000_0000;
    return $urandom();
  endfunction

  // Idle stretch length: mostly short, sometimes longer, rarely very long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  task automatic push_req(logic [REQ_W-1:0] kind, logic [IDX_W-1:0] slot,
                          logic [DATA_W-1:0] data);
    req_word_t w;
    w.kind = kind;
    w.slot = slot;
    w.data = data;
    pending_reqs.push_back(w);
  endtask

  // Holds the sequencer until every queued word has been taken and answered.
  // The check is made on the falling edge, once the rising-edge updates settle.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_valid || awaited_rsps.size() != 0)
      @(negedge clk);
  endtask

  task automatic report_field(string name, logic [DATA_W-1:0] exp, logic [DATA_W-1:0] act);
    if (act !== exp) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $error("%s mismatch: expected %h, actual %h", name, exp, act);
    end
  endtask

  // Request driver. The expected response is worked out at the edge where the
  // word is taken, so the predictor sees words in exactly the order the block does.
  always @(posedge clk) begin
    req_word_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (req_valid && req_ready) begin
        awaited_rsps.push_back(list_step(req_type, index, value));
        reqs_taken++;
      end
      if (!req_valid || req_ready) begin
        if (send_gap != 0) begin
          send_gap  <= send_gap - 1;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          nxt = pending_reqs.pop_front();
          req_type  <= nxt.kind;
          index     <= nxt.slot;
          value     <= nxt.data;
          req_valid <= 1'b1;
          send_gap  <= (gaps_on && $urandom_range(0, 1) == 0) ? pick_gap() : 0;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Marker writer. Writes are only queued while the block is idle, so updating
  // the predictor's marker at the accepting edge cannot race a request.
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        marker_img = cfg_data;
        markers_set++;
      end
      if (!cfg_valid || cfg_ready) begin
        if (pending_markers.size() != 0) begin
          cfg_data  <= pending_markers.pop_front();
          cfg_valid <= 1'b1;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor with random back-pressure. Each word is checked against
  // the oldest expectation, field by field.
  always @(posedge clk) begin
    rsp_word_t want;
    if (rst) begin
      rsp_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsps_seen++;
        if (awaited_rsps.size() == 0) begin
          mismatches++;
          $error("response word arrived with no expectation waiting");
        end else begin
          want = awaited_rsps.pop_front();
          report_field("read_value", want.rd_val, read_value);
          report_field("found", DATA_W'(want.hit), DATA_W'(found));
          report_field("list_length", DATA_W'(want.len), DATA_W'(list_length));
          report_field("applied", DATA_W'(want.ok), DATA_W'(applied));
          if (want.len == LIST_DEPTH) full_seen++;
          if (!want.ok) refused_seen++;
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        rsp_ready  <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left <= pick_gap();
        rsp_ready  <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Sequencer: directed words on the empty list under the reset marker, then
  // random phases, each under a fresh marker written while the block is idle.
  initial begin
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] v;
    logic [REQ_W-1:0]  kind;
    int                phase;
    int                n;
    int                r;
    int                k;
    int                bias;
    int                grow_share;

    marker_img = SLOT_RESET;
    for (k = 0; k < LIST_DEPTH; k++) slot_image[k] = SLOT_RESET;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty list: reads past the end, a search that cannot hit, and every
    // delete and insert-at refused.
    push_req(REQ_GET,       6'd0,  32'h0);
    push_req(REQ_GET,       6'h3F, 32'h0);
    push_req(REQ_SEARCH,    6'd0,  32'hFFFF_FFFF);
    push_req(REQ_DEL_FIRST, 6'd0,  32'h0);
    push_req(REQ_DEL_AT,    6'd0,  32'h0);
    push_req(REQ_DEL_LAST,  6'd0,  32'h0);
    push_req(REQ_INS_AT,    6'd0,  32'h1);
    // Build a short list from the extreme values.
    push_req(REQ_INS_LAST,  6'd0,  32'h7FFF_FFFF);
    push_req(REQ_INS_FIRST, 6'd0,  32'h8000_0000);
    push_req(REQ_INS_AT,    6'd1,  32'h0);
    // Insert-at with the index equal to the length is refused.
    push_req(REQ_INS_AT,    6'd3,  32'h5);
    push_req(REQ_SEARCH,    6'd0,  32'h0);
    push_req(REQ_SEARCH,    6'd0,  32'h1234_5678);
    push_req(REQ_GET,       6'd1,  32'h0);
    push_req(REQ_DEL_AT,    6'd5,  32'h0);
    push_req(REQ_DEL_AT,    6'd1,  32'h0);
    // Inserting the marker itself: at the end it changes nothing visible, at the
    // front it empties the list while the old entries stay in the store.
    push_req(REQ_INS_LAST,  6'd0,  32'hFFFF_FFFF);
    push_req(REQ_INS_FIRST, 6'd0,  32'hFFFF_FFFF);
    // A set over the leading marker brings the old entries back into the list.
    push_req(REQ_SET,       6'd0,  32'h7);
    push_req(REQ_SET,       6'h3F, 32'h5A5A_5A5A);
    push_req(REQ_UNUSED_LO, 6'h3F, 32'hFFFF_FFFF);
    push_req(REQ_UNUSED_HI, 6'd0,  32'h0);
    push_req(REQ_DEL_LAST,  6'd0,  32'h0);
    push_req(REQ_DEL_FIRST, 6'd0,  32'h0);
    push_req(REQ_SEARCH,    6'd0,  32'h8000_0000);
    wait_drained();

    for (phase = 0; phase < 5; phase++) begin
      // The store keeps its contents across a marker change; only the length
      // is taken afresh, which with a zero marker first makes the list full.
      case (phase)
        0:       m = 32'h0000_0000;
        1:       m = 32'h7FFF_FFFF;
        2:       m = 32'h8000_0000;
        3:       m = $urandom();
        default: m = SLOT_RESET;
      endcase
      marker_now = m;
      pending_markers.push_back(m);
      while (pending_markers.size() != 0 || cfg_valid) @(negedge clk);

      // One phase runs with both sides at full rate.
      gaps_on = (phase != 1);

      // Fill every slot with a non-marker value, so the list is full and every
      // insert after it is refused until something is deleted.
      if (phase == 3) begin
        for (k = 0; k < LIST_DEPTH; k++) begin
          v = pick_value();
          if (v == marker_now) v = ~v;
          push_req(REQ_SET, IDX_W'(k), v);
        end
      end

      for (n = 0; n < 255; n++) begin
        // Runs of words lean towards growing, shrinking or an even mix, so the
        // length wanders between empty and full.
        if (n % 50 == 0) bias = $urandom_range(0, 2);
        grow_share = (bias == 0) ? 55 : (bias == 1) ? 15 : 35;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 2);
        if (r < 3) begin
          kind = REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
        end else if (r < 13) begin
          kind = REQ_GET;
        end else if (r < 18) begin
          kind = REQ_SET;
        end else if (r < 30) begin
          kind = REQ_SEARCH;
        end else if ($urandom_range(0, 69) < grow_share) begin
          kind = (k == 0) ? REQ_INS_FIRST : (k == 1) ? REQ_INS_AT : REQ_INS_LAST;
        end else begin
          kind = (k == 0) ? REQ_DEL_FIRST : (k == 1) ? REQ_DEL_AT : REQ_DEL_LAST;
        end
        // Small indexes land inside the list far more often.
        push_req(kind,
                 ($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 63))
                                              : IDX_W'($urandom_range(0, 15)),
                 pick_value());
      end
      // The sender waits here for every outstanding response before the next
      // marker write.
      wait_drained();
    end

    gaps_on = 1'b0;
    repeat (LIST_DEPTH + 8) @(posedge clk);

    $display("Run covered %0d request words and %0d response words under %0d marker writes.",
             reqs_taken, rsps_seen, markers_set);
    $display("The list was full in %0d responses and %0d words were refused or ignored.",
             full_seen, refused_seen);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, with every word meeting the
  // longest gap on both sides and the full walk along the cells.
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
